// ===== rtl/tci_pkg.sv =====
package tci_pkg;

    localparam int unsigned MaxPoints = 32;
    localparam int unsigned IdxW      = $clog2(MaxPoints);
    localparam int unsigned LenW      = 6;
    localparam int unsigned VoltW     = 13;
    localparam int unsigned TempW     = 16;
    localparam int unsigned PointW    = VoltW + TempW;
    localparam int unsigned NumW      = VoltW + TempW + 2;
    localparam int unsigned DivCntW   = $clog2(NumW + 1);

    localparam logic FuncWrite   = 1'b0;
    localparam logic FuncConvert = 1'b1;

    typedef struct packed {
        logic                     func;
        logic [IdxW-1:0]          point_index;
        logic [VoltW-1:0]         point_millivolts;
        logic signed [TempW-1:0]  point_temperature;
        logic [VoltW-1:0]         sample_millivolts;
    } t_req;

    typedef struct packed {
        logic signed [TempW-1:0]  temperature_tenths;
    } t_rsp;

    typedef struct packed {
        logic                     start;
        logic [NumW-1:0]          num_mag;
        logic [VoltW-1:0]         den;
    } t_div_ctl;

    typedef struct packed {
        logic                     done;
        logic [NumW-1:0]          quo;
    } t_div_sts;

endpackage

// ===== rtl/tci_if.sv =====
interface tci_req_if;
    logic            valid;
    logic            ready;
    tci_pkg::t_req   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/tci_rsp_if.sv =====
interface tci_rsp_if;
    logic            valid;
    logic            ready;
    tci_pkg::t_rsp   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/tci_ram.sv =====
module tci_ram #(
    parameter int unsigned Width = 8,
    parameter int unsigned Depth = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/tci_div.sv =====
module tci_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tci_pkg::t_div_ctl i_ctl,
    output tci_pkg::t_div_sts o_sts
);
    logic                            r_busy;
    logic                            r_done;
    logic [tci_pkg::DivCntW-1:0]     r_cnt;
    logic [tci_pkg::NumW-1:0]        r_quo;
    logic [tci_pkg::VoltW:0]         r_rem;
    logic [tci_pkg::VoltW-1:0]       r_den;
    logic [tci_pkg::VoltW+1:0]       w_shift;
    logic [tci_pkg::VoltW+1:0]       w_diff;

    assign w_shift = {r_rem, r_quo[tci_pkg::NumW-1]};
    assign w_diff  = w_shift - {2'b00, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= tci_pkg::DivCntW'(tci_pkg::NumW);
                r_quo  <= i_ctl.num_mag;
                r_rem  <= '0;
                r_den  <= i_ctl.den;
            end else if (r_busy) begin
                if (!w_diff[tci_pkg::VoltW+1]) begin
                    r_rem <= w_diff[tci_pkg::VoltW:0];
                    r_quo <= {r_quo[tci_pkg::NumW-2:0], 1'b1};
                end else begin
                    r_rem <= w_shift[tci_pkg::VoltW:0];
                    r_quo <= {r_quo[tci_pkg::NumW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == tci_pkg::DivCntW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_sts.done = r_done;
    assign o_sts.quo  = r_quo;

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("done without busy");
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt != '0)
        else $error("count zero while busy");
`endif
endmodule

// ===== rtl/thermistor_curve_interpolator_unit.sv =====
// channel   dir   payload                                       handshake
// i_req     in    func, point_index, point_millivolts,          valid/ready
//                 point_temperature, sample_millivolts
// o_rsp     out   temperature_tenths                            valid/ready
// i_cfg     in    curve_length (6 bits)                         i_cfg_we
// a write goes into the curve memory when it is accepted; a convert reads the curve memory one point per cycle
// o_rsp.valid rises once the result is known: at the first point, at the last point,
// at point i when it ends the walk on a flat segment, or after the divide when point
// i ends the walk on a sloped segment; the worst case is a divide at point 31
// reset is synchronous active low and sets curve_length to 2
// the result register holds while o_rsp.ready is low; no new request
// is taken until the previous result has been delivered
module thermistor_curve_interpolator_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    tci_req_if.sink                         i_req,
    tci_rsp_if.source                       o_rsp,
    input  logic                            i_cfg_we,
    input  logic [tci_pkg::LenW-1:0]        i_cfg_wdata
);
    typedef enum logic [2:0] {
        S_IDLE, S_FIRST, S_P0, S_PL, S_WALK, S_DIV
    } t_state;

    t_state                          r_state;
    logic [tci_pkg::LenW-1:0]        r_len;
    logic [tci_pkg::IdxW-1:0]        r_raddr;
    logic [tci_pkg::IdxW-1:0]        r_cur;
    logic [tci_pkg::IdxW-1:0]        r_last;
    logic [tci_pkg::VoltW-1:0]       r_sample;
    logic [tci_pkg::PointW-1:0]      r_prev;
    logic                            r_neg;
    logic signed [tci_pkg::TempW-1:0] r_tlo;
    logic signed [tci_pkg::TempW-1:0] r_result;
    logic                            r_rsp_valid;
    logic [tci_pkg::NumW-1:0]        r_num;
    logic [tci_pkg::VoltW-1:0]       r_den;
    logic                            r_mul_go;

    logic [tci_pkg::LenW-1:0]        w_n;
    logic                            w_we;
    logic [tci_pkg::PointW-1:0]      w_rd;
    logic [tci_pkg::VoltW-1:0]       w_v;
    logic signed [tci_pkg::TempW-1:0] w_t;
    logic [tci_pkg::VoltW-1:0]       w_pv;
    logic signed [tci_pkg::TempW-1:0] w_pt;
    logic signed [tci_pkg::TempW:0]  w_dt;
    logic [tci_pkg::TempW:0]         w_dt_mag;
    logic [tci_pkg::VoltW-1:0]       w_ds;
    logic [tci_pkg::NumW-1:0]        w_prod;
    logic signed [tci_pkg::TempW+1:0] w_q;
    tci_pkg::t_div_ctl               w_div_ctl;
    tci_pkg::t_div_sts               w_div_sts;
    logic                            w_acc;

    assign w_n = (r_len < tci_pkg::LenW'(2)) ? tci_pkg::LenW'(2) :
                 (r_len > tci_pkg::LenW'(tci_pkg::MaxPoints)) ?
                 tci_pkg::LenW'(tci_pkg::MaxPoints) : r_len;

    assign w_acc = i_req.valid && i_req.ready;
    assign w_we  = w_acc && (i_req.data.func == tci_pkg::FuncWrite);
    assign i_req.ready = (r_state == S_IDLE) && !r_rsp_valid;

    tci_ram #(.Width(tci_pkg::PointW), .Depth(tci_pkg::MaxPoints)) u_curve (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (i_req.data.point_index),
        .i_wdata ({i_req.data.point_millivolts, i_req.data.point_temperature}),
        .i_raddr (r_raddr),
        .o_rdata (w_rd)
    );

    assign w_v  = w_rd[tci_pkg::PointW-1:tci_pkg::TempW];
    assign w_t  = w_rd[tci_pkg::TempW-1:0];
    assign w_pv = r_prev[tci_pkg::PointW-1:tci_pkg::TempW];
    assign w_pt = r_prev[tci_pkg::TempW-1:0];
    assign w_dt = {w_pt[tci_pkg::TempW-1], w_pt} - {w_t[tci_pkg::TempW-1], w_t};
    assign w_dt_mag = w_dt[tci_pkg::TempW] ? (tci_pkg::TempW+1)'(-w_dt)
                                           : w_dt[tci_pkg::TempW:0];
    assign w_ds = r_sample - w_v;
    assign w_prod = tci_pkg::NumW'(w_ds) * tci_pkg::NumW'(w_dt_mag);

    assign w_div_ctl.start   = r_mul_go;
    assign w_div_ctl.num_mag = r_num;
    assign w_div_ctl.den     = r_den;

    tci_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (w_div_ctl),
        .o_sts  (w_div_sts)
    );

    assign w_q = r_neg ? -(tci_pkg::TempW+2)'(w_div_sts.quo)
                       : (tci_pkg::TempW+2)'(w_div_sts.quo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= tci_pkg::LenW'(2);
            r_rsp_valid <= 1'b0;
            r_mul_go    <= 1'b0;
            r_raddr     <= '0;
        end else begin
            r_mul_go <= 1'b0;
            if (i_cfg_we) begin
                r_len <= i_cfg_wdata;
            end
            if (o_rsp.valid && o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc && i_req.data.func == tci_pkg::FuncConvert) begin
                        r_sample <= i_req.data.sample_millivolts;
                        r_raddr  <= '0;
                        r_last   <= tci_pkg::IdxW'(w_n - 1'b1);
                        r_state  <= S_FIRST;
                    end
                end
                S_FIRST: begin
                    r_raddr <= r_last;
                    r_state <= S_P0;
                end
                S_P0: begin
                    // first point on the read port
                    if (r_sample >= w_v) begin
                        r_result    <= w_t;
                        r_rsp_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end else begin
                        r_prev  <= w_rd;
                        r_raddr <= tci_pkg::IdxW'(1);
                        r_state <= S_PL;
                    end
                end
                S_PL: begin
                    // last used point on the read port
                    if (r_sample <= w_v) begin
                        r_result    <= w_t;
                        r_rsp_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end else begin
                        r_raddr <= tci_pkg::IdxW'(2);
                        r_cur   <= tci_pkg::IdxW'(1);
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    // point r_cur on the read port, point r_cur - 1 in r_prev
                    if (r_sample >= w_v) begin
                        if (w_pv == w_v) begin
                            r_result    <= w_t;
                            r_rsp_valid <= 1'b1;
                            r_state     <= S_IDLE;
                        end else begin
                            r_tlo    <= w_t;
                            r_neg    <= w_dt[tci_pkg::TempW];
                            r_num    <= w_prod;
                            r_den    <= w_pv - w_v;
                            r_mul_go <= 1'b1;
                            r_state  <= S_DIV;
                        end
                    end else if (r_cur == r_last) begin
                        r_result    <= w_t;
                        r_rsp_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end else begin
                        r_prev  <= w_rd;
                        r_cur   <= r_cur + 1'b1;
                        r_raddr <= r_raddr + 1'b1;
                    end
                end
                S_DIV: begin
                    if (w_div_sts.done) begin
                        r_result    <= r_tlo + (tci_pkg::TempW)'(w_q);
                        r_rsp_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.valid = r_rsp_valid;
    assign o_rsp.data.temperature_tenths = r_result;

`ifndef SYNTHESIS
    a_no_req_while_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rsp_valid |-> !i_req.ready)
        else $error("request taken while result pending");
    a_div_start_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mul_go |-> r_state == S_DIV)
        else $error("divide started outside divide state");
    a_len_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> r_len == tci_pkg::LenW'(2))
        else $error("curve length not reset");
`endif
endmodule
